>>> design/form_field_extract_decode_unit_macros.svh
// Assertion macros shared by the form field decode front end and queue.
// Each macro expects clk and arst_n to be visible in the using module.
`ifndef FORM_FIELD_EXTRACT_DECODE_UNIT_MACROS_SVH
`define FORM_FIELD_EXTRACT_DECODE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFD_ASSERT_IMPLIES_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ffd_pkg.sv
// Shared types and constants for the form field extract and decode unit.
// No dependencies; used by every module of the block.
package ffd_pkg;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int KEY_LEN_W   = 5;
	localparam int CAP_W       = 10;
	localparam logic [CAP_W-1:0] CAP_RESET = 10'd64;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_KEY_FIRST = 2'd0,
		CFG_KEY_LAST  = 2'd1,
		CFG_KEY_LEN   = 2'd2,
		CFG_CAPACITY  = 2'd3
	} cfg_index_t;

	// One result as seen on the output channel.
	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       done_res;
		logic       found;
	} res_t;

	// Most results one body byte can cause.
	localparam int MAX_RES = 3;

	// All results of one body byte; count is 1 to MAX_RES, res[0] goes out first.
	typedef struct packed {
		logic [1:0]                count;
		res_t [MAX_RES-1:0]        res;
	} bundle_t;

endpackage

>>> design/ffd_front.sv
// Front end: configuration registers, key match and value decode state machine.
// Turns each accepted body byte that yields results into a bundle of them; depends on ffd_pkg.
`include "form_field_extract_decode_unit_macros.svh"

module ffd_front #(
	parameter int MAX_KEY_BYTES = 16,
	parameter int MAX_CAPACITY  = 1023
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [ffd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ffd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_take,
	input  logic [7:0]                       in_byte,
	output logic                             q_push,
	output ffd_pkg::bundle_t                 q_bundle
);

	localparam int MP_W   = $clog2(MAX_KEY_BYTES + 1);
	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int CNT_W  = $clog2(MAX_CAPACITY + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		PH_SEEK,
		PH_VALUE,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	// Hex digit decode, either case.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.nib = 4'd0;
		priority if (c >= 8'h30 && c <= 8'h39) begin
			h.nib = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.nib = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.nib = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// Configuration registers.
	logic [7:0]                    key_q [MAX_KEY_BYTES];
	logic [ffd_pkg::KEY_LEN_W-1:0] key_len_q;
	logic [ffd_pkg::CAP_W-1:0]     cap_q;

	// Parser state.
	phase_t           phase_q, phase_n;
	logic             afs_q, afs_n;
	logic [MP_W-1:0]  mp_q, mp_n;
	logic [1:0]       esc_q, esc_n;
	logic [7:0]       held_q, held_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             kf_q, kf_n;

	// Decode scratch.
	logic [MP_W-1:0]  eff_klen;
	logic [CNT_W-1:0] eff_cap;
	logic [7:0]       key_cur;
	logic             is_done;
	hex_t             hex_in, hex_held;
	logic [7:0]       cand [ffd_pkg::MAX_RES];
	logic [1:0]       ncand;
	logic [1:0]       nres;
	logic             do_plain, plain_amp, plain_pct, mismatch;
	ffd_pkg::bundle_t bundle_n;

	// Key bytes: each byte lane is written by the register that holds it.
	for (genvar j = 0; j < MAX_KEY_BYTES; j++) begin : g_key
		localparam logic [ffd_pkg::CFG_INDEX_W-1:0] SLOT =
			(j < 8) ? ffd_pkg::CFG_KEY_FIRST : ffd_pkg::CFG_KEY_LAST;
		localparam int LANE = (j % 8) * 8;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				key_q[j] <= '0;
			end else if (cfg_write_en && cfg_index == SLOT) begin
				key_q[j] <= cfg_data[LANE +: 8];
			end
		end
	end

	// Key length and output capacity registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			cap_q     <= ffd_pkg::CAP_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == ffd_pkg::CFG_KEY_LEN) begin
				key_len_q <= cfg_data[ffd_pkg::KEY_LEN_W-1:0];
			end
			if (cfg_index == ffd_pkg::CFG_CAPACITY) begin
				cap_q <= cfg_data[ffd_pkg::CAP_W-1:0];
			end
		end
	end

	// Clamp the registers to what the hardware supports.
	assign eff_klen = (32'(key_len_q) > 32'(MAX_KEY_BYTES)) ?
		MP_W'(MAX_KEY_BYTES) : MP_W'(key_len_q);
	assign eff_cap  = (32'(cap_q) > 32'(MAX_CAPACITY)) ?
		CNT_W'(MAX_CAPACITY) : CNT_W'(cap_q);
	assign key_cur  = key_q[mp_q[KIDX_W-1:0]];
	assign hex_in   = hex_decode(in_byte);
	assign hex_held = hex_decode(held_q);
	assign is_done  = (in_byte == CH_NUL);

	// Next state and result bundle for the byte on in_byte.
	always_comb begin
		phase_n  = phase_q;
		afs_n    = afs_q;
		mp_n     = mp_q;
		esc_n    = esc_q;
		held_n   = held_q;
		cnt_n    = cnt_q;
		kf_n     = kf_q;
		for (int i = 0; i < ffd_pkg::MAX_RES; i++) begin
			cand[i] = CH_NUL;
		end
		ncand     = 2'd0;
		nres      = 2'd0;
		do_plain  = 1'b0;
		plain_amp = 1'b0;
		plain_pct = 1'b0;
		mismatch  = 1'b0;
		bundle_n  = '0;

		// Classify the byte into characters to emit and a trailing action.
		if (is_done) begin
			if (phase_q == PH_VALUE && esc_q != 2'd0) begin
				cand[0] = CH_PCT;
				ncand   = 2'd1;
				if (esc_q == 2'd2) begin
					cand[1] = held_q;
					ncand   = 2'd2;
				end
			end
		end else if (phase_q == PH_SEEK) begin
			if (!afs_q) begin
				if (in_byte == CH_AMP) begin
					afs_n = 1'b1;
					mp_n  = '0;
				end
			end else if (mp_q < eff_klen) begin
				if (in_byte == key_cur) begin
					mp_n = mp_q + 1'b1;
				end else begin
					mismatch = 1'b1;
				end
			end else if (in_byte == CH_EQ) begin
				phase_n = PH_VALUE;
				kf_n    = 1'b1;
			end else begin
				mismatch = 1'b1;
			end
			if (mismatch) begin
				mp_n  = '0;
				afs_n = (in_byte == CH_AMP);
			end
		end else if (phase_q == PH_VALUE) begin
			esc_n = 2'd0;
			if (esc_q == 2'd1) begin
				if (hex_in.ok) begin
					held_n = in_byte;
					esc_n  = 2'd2;
				end else begin
					cand[0]  = CH_PCT;
					ncand    = 2'd1;
					do_plain = 1'b1;
				end
			end else if (esc_q == 2'd2) begin
				if (hex_in.ok && hex_held.ok) begin
					cand[0] = {hex_held.nib, hex_in.nib};
					ncand   = 2'd1;
				end else begin
					cand[0]  = CH_PCT;
					cand[1]  = held_q;
					ncand    = 2'd2;
					do_plain = 1'b1;
				end
			end else begin
				do_plain = 1'b1;
			end
		end

		// A plain value character: separator, space, escape start or literal.
		if (do_plain) begin
			priority if (in_byte == CH_AMP) begin
				plain_amp = 1'b1;
			end else if (in_byte == CH_PLUS) begin
				cand[ncand] = CH_SPACE;
				ncand       = ncand + 2'd1;
			end else if (in_byte == CH_PCT) begin
				plain_pct = 1'b1;
			end else begin
				cand[ncand] = in_byte;
				ncand       = ncand + 2'd1;
			end
		end

		// Emit in order; the first byte that does not fit ends the value.
		for (int i = 0; i < ffd_pkg::MAX_RES; i++) begin
			if (2'(i) < ncand && phase_n == PH_VALUE) begin
				if (({1'b0, cnt_n} + 1'b1) < {1'b0, eff_cap}) begin
					bundle_n.res[nres].value_byte = cand[i];
					bundle_n.res[nres].byte_valid = 1'b1;
					nres  = nres + 2'd1;
					cnt_n = cnt_n + 1'b1;
				end else begin
					phase_n = PH_TAIL;
				end
			end
		end

		if (phase_n == PH_VALUE) begin
			if (plain_amp) begin
				phase_n = PH_TAIL;
			end
			if (plain_pct) begin
				esc_n = 2'd1;
			end
		end

		// End of body: report and start over.
		if (is_done) begin
			bundle_n.res[nres].done_res = 1'b1;
			bundle_n.res[nres].found    = kf_q && (eff_cap != '0);
			nres    = nres + 2'd1;
			phase_n = PH_SEEK;
			afs_n   = 1'b1;
			mp_n    = '0;
			esc_n   = 2'd0;
			held_n  = '0;
			cnt_n   = '0;
			kf_n    = 1'b0;
		end
		bundle_n.count = nres;
	end

	assign q_push   = in_take && (nres != 2'd0);
	assign q_bundle = bundle_n;

	// Parser state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			afs_q   <= 1'b1;
			mp_q    <= '0;
			esc_q   <= 2'd0;
			held_q  <= '0;
			cnt_q   <= '0;
			kf_q    <= 1'b0;
		end else if (in_take) begin
			phase_q <= phase_n;
			afs_q   <= afs_n;
			mp_q    <= mp_n;
			esc_q   <= esc_n;
			held_q  <= held_n;
			cnt_q   <= cnt_n;
			kf_q    <= kf_n;
		end
	end

	`FFD_ASSERT_IMPLIES_NEXT(a_done_clears, in_take && is_done, (phase_q == PH_SEEK) && (cnt_q == '0) && !kf_q, "State not cleared after end of body")
	`FFD_ASSERT_IMPLIES(a_seek_not_found, phase_q == PH_SEEK, !kf_q, "Key marked found while still seeking")
	`FFD_ASSERT_IMPLIES(a_escape_in_value, esc_q != 2'd0, phase_q == PH_VALUE, "Escape held outside the value")

endmodule

>>> design/ffd_queue.sv
// Short queue of result bundles between the front and back ends.
// Depends on ffd_pkg for the bundle type.
`include "form_field_extract_decode_unit_macros.svh"

module ffd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ffd_pkg::bundle_t push_bundle,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output ffd_pkg::bundle_t head
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	ffd_pkg::bundle_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W + 1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bundle;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`FFD_ASSERT_IMPLIES(a_no_overflow, push, !full || pop, "Push into a full queue")
	`FFD_ASSERT_IMPLIES(a_no_underflow, pop, !empty, "Pop from an empty queue")
	`FFD_ASSERT_IMPLIES_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "Fill count missed a push")

endmodule

>>> design/ffd_back.sv
// Back end: unpacks queued bundles into single results on the output channel.
// Depends on ffd_pkg for the bundle and result types.
module ffd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ffd_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output ffd_pkg::res_t    out_res
);

	logic          out_valid_q;
	ffd_pkg::res_t out_res_q;
	logic [1:0]    idx_q;
	logic          load, last;

	// The output register takes a new result whenever the queue holds one and the register is empty or being taken.
	assign load = !empty && (!out_valid_q || !out_stall);
	assign last = ((idx_q + 2'd1) == head.count);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= head.res[idx_q];
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

>>> design/form_field_extract_decode_unit.sv
// Form field extract and decode unit. Body bytes of a form-encoded body enter one per cycle;
// a zero byte ends the body. The unit finds the first field whose name equals the configured
// key and streams that field's value, percent- and plus-decoded, one byte per transaction,
// followed by a done transaction that reports whether the key was found. Each body byte
// causes zero to three transactions. The bundle of results of a body byte enters the queue
// at the edge that accepts the byte and moves into the output register, one result at a
// time, whenever that register is empty or being taken. Input is taken every cycle while
// the four-entry bundle queue has room; the output drains one result per cycle while the
// receiver does not stall, so bytes that cause two or three results (a cut-off escape, the
// end of the body) can fill the queue and hold the input. Write configuration only between
// transactions. There is no start-up sweep: the unit is ready right after reset.
module form_field_extract_decode_unit #(
	parameter int MAX_KEY_BYTES = 16,
	parameter int MAX_CAPACITY  = 1023
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [ffd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ffd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       body_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       value_byte,
	output logic                             byte_valid,
	output logic                             done_res,
	output logic                             found
);

	logic             in_take;
	logic             q_push, q_pop, q_full, q_empty;
	ffd_pkg::bundle_t q_in, q_head;
	ffd_pkg::res_t    out_res;

	// Input transactions are taken while the queue has room.
	assign in_stall = q_full;
	assign in_take  = in_valid && !in_stall;

	ffd_front #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES),
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_take     (in_take),
		.in_byte     (body_byte),
		.q_push      (q_push),
		.q_bundle    (q_in)
	);

	ffd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_bundle(q_in),
		.pop        (q_pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (q_head)
	);

	ffd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_res  (out_res)
	);

	assign value_byte = out_res.value_byte;
	assign byte_valid = out_res.byte_valid;
	assign done_res   = out_res.done_res;
	assign found      = out_res.found;

endmodule

>>> tb/sv/ffd_checker.sv
// Checker for the form field extract and decode unit: follows configuration writes and both
// channels, predicts the decoded value stream and compares every output transaction.
// Depends on ffd_pkg for the register indexes and the result layout.
module ffd_checker #(
	parameter int KEY_MAX = 16,
	parameter int CAP_MAX = 1023
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [ffd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ffd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [7:0]                      body_byte,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [7:0]                      value_byte,
	input  logic                            byte_valid,
	input  logic                            done_res,
	input  logic                            found,
	output int                              pending,
	output int                              errors,
	output int                              results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] AMP   = "&";
	localparam logic [7:0] EQ    = "=";
	localparam logic [7:0] PLUS  = "+";
	localparam logic [7:0] PCT   = "%";
	localparam logic [7:0] SPACE = " ";

	typedef enum logic [1:0] {SCAN_SEEK, SCAN_VALUE, SCAN_TAIL} scan_t;

	// Shadow copy of the registers.
	logic [63:0]    key_lo_w;
	logic [63:0]    key_hi_w;
	logic [4:0]     key_len_r;
	logic [ffd_pkg::CAP_W-1:0] cap_r;

	// Scanner state of the current body.
	scan_t          scan;
	logic           field_start;
	logic [4:0]     match_pos;
	logic [1:0]     esc_cnt;
	logic [7:0]     esc_digit;
	int             out_cnt;
	logic           hit;

	// Decoded results still to come out of the block, oldest first.
	ffd_pkg::res_t  value_q[$];
	int             err_cnt;
	int             seen_cnt;

	function automatic int key_len_eff();
		return (int'(key_len_r) > KEY_MAX) ? KEY_MAX : int'(key_len_r);
	endfunction

	function automatic int cap_eff();
		return (int'(cap_r) > CAP_MAX) ? CAP_MAX : int'(cap_r);
	endfunction

	function automatic logic [7:0] key_at(int i);
		if (i < 8) begin
			return key_lo_w[i*8 +: 8];
		end
		return key_hi_w[(i-8)*8 +: 8];
	endfunction

	function automatic int hex_of(logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end
		if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end
		if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		return -1;
	endfunction

	task automatic clear_scan();
		scan        = SCAN_SEEK;
		field_start = 1'b1;
		match_pos   = '0;
		esc_cnt     = '0;
		esc_digit   = '0;
		out_cnt     = 0;
		hit         = 1'b0;
	endtask

	task automatic push_res(logic [7:0] v, logic bv, logic dn, logic fd);
		ffd_pkg::res_t r;
		r.value_byte = v;
		r.byte_valid = bv;
		r.done_res   = dn;
		r.found      = fd;
		value_q.push_back(r);
	endtask

	// A byte that no longer fits ends decoding for the rest of the body.
	task automatic emit_char(logic [7:0] c);
		if (scan != SCAN_VALUE) begin
			return;
		end
		if (out_cnt + 1 < cap_eff()) begin
			push_res(c, 1'b1, 1'b0, 1'b0);
			out_cnt++;
		end else begin
			scan = SCAN_TAIL;
		end
	endtask

	task automatic plain_char(logic [7:0] b);
		if (scan != SCAN_VALUE) begin
			return;
		end
		if (b == AMP) begin
			scan = SCAN_TAIL;
		end else if (b == PLUS) begin
			emit_char(SPACE);
		end else if (b == PCT) begin
			esc_cnt = 2'd1;
		end else begin
			emit_char(b);
		end
	endtask

	// Value byte: completes, breaks or skips a percent escape.
	task automatic value_char(logic [7:0] b);
		int hi;
		int lo;
		if (esc_cnt == 2'd1) begin
			esc_cnt = 2'd0;
			if (hex_of(b) >= 0) begin
				esc_digit = b;
				esc_cnt   = 2'd2;
			end else begin
				emit_char(PCT);
				plain_char(b);
			end
		end else if (esc_cnt == 2'd2) begin
			hi      = hex_of(esc_digit);
			lo      = hex_of(b);
			esc_cnt = 2'd0;
			if (hi >= 0 && lo >= 0) begin
				emit_char(8'(hi * 16 + lo));
			end else begin
				emit_char(PCT);
				emit_char(esc_digit);
				plain_char(b);
			end
		end else begin
			plain_char(b);
		end
	endtask

	// Name matching: only a field start can match, and the key must be followed by '='.
	task automatic seek_char(logic [7:0] b);
		int klen;
		klen = key_len_eff();
		if (!field_start) begin
			if (b == AMP) begin
				field_start = 1'b1;
				match_pos   = '0;
			end
			return;
		end
		if (int'(match_pos) < klen) begin
			if (b == key_at(int'(match_pos))) begin
				match_pos++;
				return;
			end
		end else if (b == EQ) begin
			scan = SCAN_VALUE;
			hit  = 1'b1;
			return;
		end
		match_pos   = '0;
		field_start = (b == AMP);
	endtask

	// One body byte in, zero to three decoded results out.
	task automatic take_byte(logic [7:0] b);
		int held;
		if (b == 8'h00) begin
			if (scan == SCAN_VALUE) begin
				held    = int'(esc_cnt);
				esc_cnt = 2'd0;
				if (held >= 1) begin
					emit_char(PCT);
				end
				if (held == 2) begin
					emit_char(esc_digit);
				end
			end
			push_res(8'h00, 1'b0, 1'b1, hit && cap_eff() != 0);
			clear_scan();
		end else if (scan == SCAN_SEEK) begin
			seek_char(b);
		end else if (scan == SCAN_VALUE) begin
			value_char(b);
		end
	endtask

	// Sample at the clock edge: register writes, accepted bytes, accepted results.
	always @(posedge clk or negedge arst_n) begin
		ffd_pkg::res_t want;
		if (!arst_n) begin
			key_lo_w  = '0;
			key_hi_w  = '0;
			key_len_r = '0;
			cap_r     = ffd_pkg::CAP_RESET;
			clear_scan();
			value_q.delete();
			err_cnt   = 0;
			seen_cnt  = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					ffd_pkg::CFG_KEY_FIRST: key_lo_w  = cfg_data;
					ffd_pkg::CFG_KEY_LAST:  key_hi_w  = cfg_data;
					ffd_pkg::CFG_KEY_LEN:   key_len_r = cfg_data[ffd_pkg::KEY_LEN_W-1:0];
					ffd_pkg::CFG_CAPACITY:  cap_r     = cfg_data[ffd_pkg::CAP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				take_byte(body_byte);
			end
			if (out_valid && !out_stall) begin
				seen_cnt++;
				if (value_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected transaction: expected none, got value_byte=%h %s%b %s%b %s%b",
						$time, value_byte, "byte_valid=", byte_valid, "done_res=", done_res,
						"found=", found);
				end else begin
					want = value_q.pop_front();
					if (value_byte !== want.value_byte || byte_valid !== want.byte_valid ||
							done_res !== want.done_res || found !== want.found) begin
						err_cnt++;
						$display("%0t: mismatch: expected value_byte=%h byte_valid=%b done_res=%b found=%b",
							$time, want.value_byte, want.byte_valid, want.done_res, want.found);
						$display("%0t:           actual value_byte=%h byte_valid=%b done_res=%b found=%b",
							$time, value_byte, byte_valid, done_res, found);
					end
				end
			end
		end
		pending      <= value_q.size();
		errors       <= err_cnt;
		results_seen <= seen_cnt;
	end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the form field extract and decode unit: clock, reset, register setup,
// form-encoded body stimulus with random idling, and the verdict.
// Depends on ffd_pkg, form_field_extract_decode_unit and ffd_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 460;
	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 100;

	localparam logic [7:0] AMP  = "&";
	localparam logic [7:0] EQ   = "=";
	localparam logic [7:0] PLUS = "+";
	localparam logic [7:0] PCT  = "%";

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_write_en = 1'b0;
	ffd_pkg::cfg_index_t cfg_index    = ffd_pkg::CFG_KEY_FIRST;
	logic [63:0]         cfg_data     = '0;
	logic                in_valid     = 1'b0;
	logic [7:0]          body_byte    = '0;
	logic                out_stall    = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic [7:0]          value_byte;
	logic                byte_valid;
	logic                done_res;
	logic                found;

	int                pending;
	int                errors;
	int                results_seen;

	int                cycle_cnt     = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                hold_req      = 0;
	int                hold_seen     = 0;
	int                hold_left     = 0;
	int                items_sent    = 0;
	int                n_bodies      = 0;
	int                n_settings    = 0;
	int                key_eff       = 0;
	logic [7:0]        key_chars[16];
	logic [7:0]        body_q[$];

	form_field_extract_decode_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.body_byte    (body_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value_byte   (value_byte),
		.byte_valid   (byte_valid),
		.done_res     (done_res),
		.found        (found)
	);

	ffd_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.body_byte    (body_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value_byte   (value_byte),
		.byte_valid   (byte_valid),
		.done_res     (done_res),
		.found        (found),
		.pending      (pending),
		.errors       (errors),
		.results_seen (results_seen)
	);

	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic set_idle(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	// One transaction on the body channel, after a random number of idle cycles.
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		body_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Stop sending until every expected result is out and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers; the upper data bits of the narrow ones carry noise.
	task automatic load_config(int len, int cap);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] d;
		for (int i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = key_chars[i];
			hi[i*8 +: 8] = key_chars[i+8];
		end
		cfg_write_en <= 1'b1;
		cfg_index    <= ffd_pkg::CFG_KEY_FIRST;
		cfg_data     <= lo;
		@(posedge clk);
		cfg_index <= ffd_pkg::CFG_KEY_LAST;
		cfg_data  <= hi;
		@(posedge clk);
		d = {$urandom, $urandom};
		d[ffd_pkg::KEY_LEN_W-1:0] = ffd_pkg::KEY_LEN_W'(len);
		cfg_index <= ffd_pkg::CFG_KEY_LEN;
		cfg_data  <= d;
		@(posedge clk);
		d = {$urandom, $urandom};
		d[ffd_pkg::CAP_W-1:0] = ffd_pkg::CAP_W'(cap);
		cfg_index <= ffd_pkg::CFG_CAPACITY;
		cfg_data  <= d;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		key_eff = (len > 16) ? 16 : len;
		n_settings++;
	endtask

	function automatic logic [7:0] letter();
		return 8'(int'("a") + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) begin
			return 8'(int'("0") + r);
		end
		if (r < 16) begin
			return 8'(int'("a") + r - 10);
		end
		return 8'(int'("A") + r - 16);
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(1, 255));
		end while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
		return c;
	endfunction

	// Key characters come mostly from a tiny alphabet so that partial matches are common.
	function automatic logic [7:0] key_char();
		int r;
		r = $urandom_range(0, 39);
		if (r == 0) begin
			return 8'h00;
		end
		if (r < 3) begin
			return AMP;
		end
		if (r < 9) begin
			return 8'($urandom_range(1, 255));
		end
		return 8'(int'("a") + $urandom_range(0, 2));
	endfunction

	task automatic push_text(string t);
		foreach (t[i]) begin
			body_q.push_back(t[i]);
		end
	endtask

	task automatic add_key(int n);
		for (int i = 0; i < n; i++) begin
			body_q.push_back(key_chars[i]);
		end
	endtask

	// Field value with plain bytes, plus signs, good and broken escapes.
	task automatic add_value();
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3: body_q.push_back(letter());
				4: body_q.push_back(PLUS);
				5: begin
					body_q.push_back(PCT);
					body_q.push_back(hex_char());
					body_q.push_back(hex_char());
				end
				6: begin
					body_q.push_back(PCT);
					body_q.push_back(hex_char());
					body_q.push_back(non_hex_char());
				end
				7: begin
					body_q.push_back(PCT);
					body_q.push_back(non_hex_char());
				end
				8: body_q.push_back(8'($urandom_range(1, 255)));
				9: push_text("%00");
				10: push_text("%26");
				default: begin
					body_q.push_back(PCT);
					body_q.push_back(hex_char());
					body_q.push_back(PCT);
				end
			endcase
		end
	endtask

	task automatic send_queued();
		foreach (body_q[i]) begin
			send_byte(body_q[i]);
		end
		body_q.delete();
		n_bodies++;
	endtask

	// Mostly well-formed bodies built around the key; some are pure noise.
	task automatic send_body();
		body_q.delete();
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 15)) body_q.push_back(8'($urandom_range(1, 255)));
		end else begin
			for (int f = 0; f < $urandom_range(1, 3); f++) begin
				if (f > 0) begin
					body_q.push_back(AMP);
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						add_key(key_eff);
						body_q.push_back(EQ);
					end
					4: begin
						add_key($urandom_range(0, key_eff));
						body_q.push_back(letter());
						body_q.push_back(EQ);
					end
					5: begin
						add_key(key_eff);
						body_q.push_back(letter());
						body_q.push_back(EQ);
					end
					6: add_key(key_eff);
					7: begin
						repeat ($urandom_range(1, 4)) body_q.push_back(letter());
						body_q.push_back(EQ);
					end
					default: body_q.push_back(EQ);
				endcase
				add_value();
			end
			// Sometimes the body ends in the middle of an escape.
			case ($urandom_range(0, 9))
				0: body_q.push_back(PCT);
				1: begin
					body_q.push_back(PCT);
					body_q.push_back(hex_char());
				end
				default: ;
			endcase
		end
		body_q.push_back(8'h00);
		send_queued();
	endtask

	initial begin
		int len;
		int cap;
		int s;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed body: key "ab", plus sign, escapes good, broken and cut off, byte 0xFF.
		set_idle(36, 67);
		foreach (key_chars[i]) begin
			key_chars[i] = key_char();
		end
		key_chars[0] = "a";
		key_chars[1] = "b";
		load_config(2, 64);
		push_text("ab=");
		body_q.push_back(8'hFF);
		push_text("+%4a%2g%00%26%2");
		body_q.push_back(8'h00);
		send_queued();

		// Long value while the receiver holds off, so the block backs up into its input.
		hold_req <= hold_req + 1;
		push_text("ab=");
		repeat (30) body_q.push_back(letter());
		body_q.push_back(8'h00);
		send_queued();

		// Random part: each register setting gets a few bodies, with the block drained first.
		s = 0;
		while (items_sent < ITEMS) begin
			drain();
			if (items_sent < ITEMS / 3) begin
				set_idle(36, 67);
			end else if (items_sent < 2 * ITEMS / 3) begin
				set_idle(67, 36);
			end else begin
				set_idle(0, 0);
			end
			foreach (key_chars[i]) begin
				key_chars[i] = key_char();
			end
			case (s)
				0: begin
					len = $urandom_range(1, 16);
					cap = 3;
				end
				1: begin
					len = 0;
					cap = 0;
					foreach (key_chars[i]) key_chars[i] = 8'h00;
				end
				2: begin
					len = 31;
					cap = 1;
				end
				3: begin
					len = 16;
					cap = 1023;
					foreach (key_chars[i]) key_chars[i] = 8'hFF;
				end
				default: begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
					cap = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 40) : $urandom_range(0, 1023);
				end
			endcase
			load_config(len, cap);
			repeat ($urandom_range(1, 3)) send_body();
			s++;
		end

		drain();
		repeat (4) @(posedge clk);
		$display("Covered %0d body bytes in %0d bodies under %0d register settings,",
			items_sent, n_bodies, n_settings);
		$display("with %0d output transactions compared against the predicted value stream.",
			results_seen);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> form_field_extract_decode_unit.f
+incdir+design
design/ffd_pkg.sv
design/ffd_front.sv
design/ffd_queue.sv
design/ffd_back.sv
design/form_field_extract_decode_unit.sv
tb/sv/ffd_checker.sv
tb/sv/tb_top.sv
